>>> hdl/lock_mode_and_light_controller_macros.svh
// Assertion macros shared by the lock mode and light controller.
`ifndef LOCK_MODE_AND_LIGHT_CONTROLLER_MACROS_SVH
`define LOCK_MODE_AND_LIGHT_CONTROLLER_MACROS_SVH

// The consequent must hold in the clock after the antecedent.
`define LMLC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

// The consequent must hold in the same clock as the antecedent.
`define LMLC_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

`endif

>>> hdl/lmlc_pkg.sv
// Package with the types, codes and helper functions of the lock mode and light controller.
`timescale 1ns / 1ps

package lmlc_pkg;

   localparam int COUNT_WIDTH = 20;
   localparam int DELAY_WIDTH = 20;
   localparam int LEVEL_WIDTH = 7;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 20;
   localparam int WIDE_WIDTH = 33;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Request operation codes.
   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_DOOR = 3'd1;
   localparam logic [2:0] OP_BUTTON = 3'd2;
   localparam logic [2:0] OP_RADIO_ERROR = 3'd3;
   localparam logic [2:0] OP_CONNECT = 3'd4;
   localparam logic [2:0] OP_DISCONNECT = 3'd5;
   localparam logic [2:0] OP_UNLOCK = 3'd6;
   localparam logic [2:0] OP_OPEN = 3'd7;

   // Light command codes.
   localparam logic [3:0] LIGHT_NONE = 4'd0;
   localparam logic [3:0] LIGHT_OFF_NOW = 4'd1;
   localparam logic [3:0] LIGHT_OFF_FADE_SHORT = 4'd2;
   localparam logic [3:0] LIGHT_OFF_FADE_LONG = 4'd3;
   localparam logic [3:0] LIGHT_RED = 4'd4;
   localparam logic [3:0] LIGHT_GREEN_PULSE = 4'd5;
   localparam logic [3:0] LIGHT_BLUE_PULSE = 4'd6;
   localparam logic [3:0] LIGHT_BLUE = 4'd7;
   localparam logic [3:0] LIGHT_WHITE = 4'd8;
   localparam logic [3:0] LIGHT_YELLOW = 4'd9;
   localparam logic [3:0] LIGHT_RED_BLINK = 4'd10;
   localparam logic [3:0] LIGHT_WHITE_BLINK = 4'd11;

   // Lock and bond action codes.
   localparam logic [1:0] LOCK_NONE = 2'd0;
   localparam logic [1:0] LOCK_UNLOCK = 2'd1;
   localparam logic [1:0] LOCK_LOCK = 2'd2;
   localparam logic [1:0] BOND_NONE = 2'd0;
   localparam logic [1:0] BOND_ENTER = 2'd1;
   localparam logic [1:0] BOND_LEAVE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESTART = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_OFF = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLEAR_HOLD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOND_EXIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLASH_WAIT = 3'd5;

   // Mode flag bit positions.
   localparam int FL_ERROR = 0;
   localparam int FL_BONDING = 1;
   localparam int FL_UNLOCKED = 2;
   localparam int FL_OPENED = 3;
   localparam int FL_CONNECTED = 4;
   localparam int FLAG_WIDTH = 5;

   typedef struct packed {
      logic [2:0] operation;
      logic door_open;
      logic button_pressed;
      logic [LEVEL_WIDTH-1:0] ambient_brightness;
      logic lock_engaged;
   } req_type;

   typedef struct packed {
      logic [3:0] light_command;
      logic [1:0] lock_action;
      logic open_strobe;
      logic [1:0] bond_action;
      logic clear_pairings;
      logic system_reset;
      logic status_led_on;
      logic door_report_valid;
      logic door_report_open;
      logic bonding_active;
      logic connected_active;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] brightness_threshold;
      logic [DELAY_WIDTH-1:0] restart_delay;
      logic [DELAY_WIDTH-1:0] light_off_delay;
      logic [DELAY_WIDTH-1:0] clear_hold_delay;
      logic [DELAY_WIDTH-1:0] bond_exit_delay;
      logic [DELAY_WIDTH-1:0] flash_wait_delay;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic stop;
      logic load;
      logic [COUNT_WIDTH-1:0] value;
   } timer_ctrl_type;

   typedef struct packed {
      logic active;
      logic expire;
   } timer_stat_type;

   localparam logic [LEVEL_WIDTH-1:0] RESET_THRESHOLD = LEVEL_WIDTH'(50);
   localparam logic [DELAY_WIDTH-1:0] RESET_RESTART = DELAY_WIDTH'(60000);
   localparam logic [DELAY_WIDTH-1:0] RESET_LIGHT_OFF = DELAY_WIDTH'(900000);
   localparam logic [DELAY_WIDTH-1:0] RESET_CLEAR_HOLD = DELAY_WIDTH'(3000);
   localparam logic [DELAY_WIDTH-1:0] RESET_BOND_EXIT = DELAY_WIDTH'(10000);
   localparam logic [DELAY_WIDTH-1:0] RESET_FLASH_WAIT = DELAY_WIDTH'(600);

   // Limits a configured delay to the largest value the counter holds.
   function automatic logic [COUNT_WIDTH-1:0] sat_delay(input logic [DELAY_WIDTH-1:0] delay);
      logic [WIDE_WIDTH-1:0] wide_delay;
      logic [WIDE_WIDTH-1:0] wide_max;
      wide_delay = WIDE_WIDTH'(delay);
      wide_max = WIDE_WIDTH'(COUNT_MAX);
      return (wide_delay > wide_max) ? COUNT_MAX : COUNT_WIDTH'(wide_delay);
   endfunction

   // Priority light selection from the flags now and at the last light update.
   function automatic logic [3:0] light_select(input logic [FLAG_WIDTH-1:0] flags,
                                               input logic [FLAG_WIDTH-1:0] prev,
                                               input logic [LEVEL_WIDTH-1:0] ambient,
                                               input logic [LEVEL_WIDTH-1:0] threshold);
      logic [3:0] on_colour;
      logic [3:0] cmd;
      on_colour = (ambient <= threshold) ? LIGHT_WHITE : LIGHT_YELLOW;
      if (flags[FL_ERROR]) begin
         cmd = LIGHT_RED;
      end else if (flags[FL_BONDING]) begin
         cmd = prev[FL_BONDING] ? LIGHT_NONE : LIGHT_GREEN_PULSE;
      end else if (flags[FL_CONNECTED]) begin
         if (flags[FL_OPENED]) begin
            cmd = on_colour;
         end else if (flags[FL_UNLOCKED]) begin
            cmd = LIGHT_BLUE;
         end else begin
            cmd = LIGHT_BLUE_PULSE;
         end
      end else if (flags[FL_OPENED]) begin
         cmd = prev[FL_CONNECTED] ? LIGHT_RED_BLINK : on_colour;
      end else if (prev[FL_CONNECTED]) begin
         cmd = LIGHT_OFF_FADE_LONG;
      end else begin
         cmd = LIGHT_OFF_FADE_SHORT;
      end
      return cmd;
   endfunction

endpackage

>>> hdl/lmlc_timer.sv
// Countdown timer with an active bit, loaded, stopped or ticked by the controller.
`timescale 1ns / 1ps

module lmlc_timer
   import lmlc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  timer_ctrl_type ctrl,
   output timer_stat_type stat
);

   logic                   active_ff;
   logic                   active_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   expire;

   assign expire = ctrl.tick && active_ff && (count_ff <= COUNT_WIDTH'(1));

   // A load or a stop later in the same request overrides the tick.
   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      if (ctrl.load) begin
         active_in = 1'b1;
         count_in  = ctrl.value;
      end else if (ctrl.stop || expire) begin
         active_in = 1'b0;
         count_in  = '0;
      end else if (ctrl.tick && active_ff) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   assign stat.active = active_ff;
   assign stat.expire = expire;

endmodule

>>> hdl/lmlc_csr.sv
// Configuration registers with their reset values.
`timescale 1ns / 1ps

module lmlc_csr
   import lmlc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes to indexes beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:  cfg_in.brightness_threshold = csr_data[LEVEL_WIDTH-1:0];
            CSR_RESTART:    cfg_in.restart_delay = csr_data[DELAY_WIDTH-1:0];
            CSR_LIGHT_OFF:  cfg_in.light_off_delay = csr_data[DELAY_WIDTH-1:0];
            CSR_CLEAR_HOLD: cfg_in.clear_hold_delay = csr_data[DELAY_WIDTH-1:0];
            CSR_BOND_EXIT:  cfg_in.bond_exit_delay = csr_data[DELAY_WIDTH-1:0];
            CSR_FLASH_WAIT: cfg_in.flash_wait_delay = csr_data[DELAY_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness_threshold <= RESET_THRESHOLD;
         cfg_ff.restart_delay        <= RESET_RESTART;
         cfg_ff.light_off_delay      <= RESET_LIGHT_OFF;
         cfg_ff.clear_hold_delay     <= RESET_CLEAR_HOLD;
         cfg_ff.bond_exit_delay      <= RESET_BOND_EXIT;
         cfg_ff.flash_wait_delay     <= RESET_FLASH_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/lmlc_core.sv
// Event logic: mode flags, the four timers, the clear-flash flag and the result of one request.
`timescale 1ns / 1ps

module lmlc_core
   import lmlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_fire,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [FLAG_WIDTH-1:0] flags_ff;
   logic [FLAG_WIDTH-1:0] flags_in;
   logic [FLAG_WIDTH-1:0] prev_ff;
   logic [FLAG_WIDTH-1:0] prev_in;
   logic                  flash_ff;
   logic                  flash_in;

   timer_ctrl_type restart_ctrl;
   timer_ctrl_type light_off_ctrl;
   timer_ctrl_type clear_ctrl;
   timer_ctrl_type bond_exit_ctrl;
   timer_stat_type restart_stat;
   timer_stat_type light_off_stat;
   timer_stat_type clear_stat;
   timer_stat_type bond_exit_stat;

   logic       light_update;
   logic [3:0] chosen_light;
   logic       off_timer_load;

   lmlc_timer u_restart (.clock(clock), .reset(reset), .ctrl(restart_ctrl),
                         .stat(restart_stat));
   lmlc_timer u_light_off (.clock(clock), .reset(reset), .ctrl(light_off_ctrl),
                           .stat(light_off_stat));
   lmlc_timer u_clear (.clock(clock), .reset(reset), .ctrl(clear_ctrl),
                       .stat(clear_stat));
   lmlc_timer u_bond_exit (.clock(clock), .reset(reset), .ctrl(bond_exit_ctrl),
                           .stat(bond_exit_stat));

   always_comb begin
      flags_in       = flags_ff;
      prev_in        = prev_ff;
      flash_in       = flash_ff;
      rsp            = '0;
      restart_ctrl   = '0;
      light_off_ctrl = '0;
      clear_ctrl     = '0;
      bond_exit_ctrl = '0;
      light_update   = 1'b0;
      chosen_light   = LIGHT_NONE;
      off_timer_load = 1'b0;
      restart_ctrl.value   = sat_delay(cfg.restart_delay);
      light_off_ctrl.value = sat_delay(cfg.light_off_delay);
      clear_ctrl.value     = sat_delay(cfg.clear_hold_delay);
      bond_exit_ctrl.value = sat_delay(cfg.bond_exit_delay);
      if (step_fire) begin
         case (req.operation)
            OP_TICK: begin
               restart_ctrl.tick   = 1'b1;
               light_off_ctrl.tick = 1'b1;
               clear_ctrl.tick     = 1'b1;
               bond_exit_ctrl.tick = 1'b1;
               rsp.system_reset    = restart_stat.expire;
               if (light_off_stat.expire) begin
                  rsp.light_command = LIGHT_OFF_NOW;
               end
               if (clear_stat.expire) begin
                  if (!flash_ff) begin
                     rsp.clear_pairings = 1'b1;
                     rsp.light_command  = LIGHT_WHITE_BLINK;
                     clear_ctrl.load    = 1'b1;
                     clear_ctrl.value   = sat_delay(cfg.flash_wait_delay);
                     flash_in           = 1'b1;
                  end else begin
                     flash_in         = 1'b0;
                     rsp.system_reset = 1'b1;
                  end
               end
               if (bond_exit_stat.expire) begin
                  rsp.bond_action      = BOND_LEAVE;
                  flags_in[FL_BONDING] = 1'b0;
                  light_update         = 1'b1;
               end
            end
            OP_DOOR: begin
               rsp.door_report_valid = 1'b1;
               rsp.door_report_open  = req.door_open;
               flags_in[FL_OPENED]   = req.door_open;
               light_update          = 1'b1;
            end
            OP_BUTTON: begin
               if (req.button_pressed) begin
                  if (flags_ff[FL_BONDING]) begin
                     bond_exit_ctrl.stop  = 1'b1;
                     rsp.bond_action      = BOND_LEAVE;
                     flags_in[FL_BONDING] = 1'b0;
                     light_update         = 1'b1;
                  end else begin
                     clear_ctrl.load = 1'b1;
                  end
               end else if (!flash_ff) begin
                  if (clear_stat.active && !flags_ff[FL_BONDING]) begin
                     rsp.bond_action      = BOND_ENTER;
                     flags_in[FL_BONDING] = 1'b1;
                     light_update         = 1'b1;
                     bond_exit_ctrl.load  = 1'b1;
                  end
                  clear_ctrl.stop = 1'b1;
               end
            end
            OP_RADIO_ERROR: begin
               rsp.status_led_on  = 1'b1;
               restart_ctrl.load  = 1'b1;
               flags_in[FL_ERROR] = 1'b1;
               light_update       = 1'b1;
            end
            OP_CONNECT: begin
               bond_exit_ctrl.stop    = 1'b1;
               flags_in[FL_CONNECTED] = 1'b1;
               flags_in[FL_BONDING]   = 1'b0;
               light_update           = 1'b1;
            end
            OP_DISCONNECT: begin
               rsp.lock_action        = LOCK_LOCK;
               flags_in[FL_UNLOCKED]  = 1'b0;
               flags_in[FL_CONNECTED] = 1'b0;
               light_update           = 1'b1;
            end
            OP_UNLOCK: begin
               if (flags_ff[FL_CONNECTED]) begin
                  rsp.lock_action       = LOCK_UNLOCK;
                  flags_in[FL_UNLOCKED] = 1'b1;
                  light_update          = 1'b1;
               end
            end
            OP_OPEN: begin
               rsp.open_strobe = !req.lock_engaged;
            end
            default: begin
               rsp = '0;
            end
         endcase
         // A light update restarts or stops the light-off timer and records the flags.
         if (light_update) begin
            chosen_light = light_select(flags_in, prev_ff, req.ambient_brightness,
                                        cfg.brightness_threshold);
            off_timer_load = !flags_in[FL_ERROR] && !flags_in[FL_BONDING] &&
                             !flags_in[FL_CONNECTED] && flags_in[FL_OPENED];
            light_off_ctrl.load = off_timer_load;
            light_off_ctrl.stop = !off_timer_load;
            prev_in = flags_in;
            if (chosen_light != LIGHT_NONE) begin
               rsp.light_command = chosen_light;
            end
         end
      end
      rsp.bonding_active   = flags_in[FL_BONDING];
      rsp.connected_active = flags_in[FL_CONNECTED];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         prev_ff  <= '0;
         flash_ff <= 1'b0;
      end else begin
         flags_ff <= flags_in;
         prev_ff  <= prev_in;
         flash_ff <= flash_in;
      end
   end

endmodule

>>> hdl/lock_mode_and_light_controller.sv
// Top level: request and result registers around the lock mode and light controller logic.
`timescale 1ns / 1ps
`include "lock_mode_and_light_controller_macros.svh"

// Each request is taken into an input register and handled by the event logic, whose result
// lands in an output register after the input register. One request can be accepted in every
// cycle unless a stalled result holds the input register full. A request waiting in the input
// register moves on whenever the output register is empty or its result is being taken, so
// a stalled result holds back at most one further request. Configuration writes are taken
// in every cycle and must only be made while no request is in flight.
module lock_mode_and_light_controller
   import lmlc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;
   req_type in_req_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type out_rsp_in;
   logic    step_fire;
   rsp_type step_rsp;
   cfg_type cfg;

   lmlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lmlc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .req       (in_req_ff),
      .cfg       (cfg),
      .rsp       (step_rsp)
   );

   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (step_fire) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_rsp_in   = step_rsp;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_req_in   = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   `LMLC_ASSERT_NEXT(a_step_gives_result, step_fire, out_valid_ff)
   `LMLC_ASSERT_NEXT(a_open_no_light, step_fire && (in_req_ff.operation == OP_OPEN),
      (out_rsp_ff.light_command == LIGHT_NONE) && (out_rsp_ff.bond_action == BOND_NONE))
   `LMLC_ASSERT_NEXT(a_reset_only_on_tick, step_fire && (in_req_ff.operation != OP_TICK),
      !out_rsp_ff.system_reset && !out_rsp_ff.clear_pairings)
   `LMLC_ASSERT_SAME(a_stall_holds_input, in_valid_ff && out_valid_ff && !rsp_ready,
      !req_ready && !step_fire)

endmodule
